### rtl/vcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vcd_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DATA    = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_TRUNC   = 2'd2
	} status_t;

	// Header layout and chunk rules
	localparam int unsigned HDR_LAST     = 15;
	localparam logic [15:0] SKIP_TYPE    = 16'd258;
	localparam int unsigned END_FLAG_BIT = 7;
	localparam logic [15:0] HEADER_EXTRA = 16'd12;
	localparam logic [15:0] MIN_LENGTH   = HEADER_EXTRA + 16'd1;

	// Depth of the result queue between parser and output
	localparam int unsigned QUEUE_DEPTH = 4;

	// One result as it travels from the parser to the output side
	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] stamp;
		logic        first;
		logic        last;
		status_t     status;
	} result_t;

endpackage

`default_nettype wire

### rtl/vcd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vcd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       in_byte,
	input  wire logic             stream_end,
	output vcd_pkg::result_t      res,
	output logic                  res_valid
);

	logic [3:0]  header_count_q, header_count_n;
	logic [15:0] chunk_type_q, chunk_type_n;
	logic [15:0] chunk_length_q, chunk_length_n;
	logic        end_mark_q, end_mark_n;
	logic [31:0] chunk_stamp_q, chunk_stamp_n;
	logic [31:0] held_stamp_q, held_stamp_n;
	logic [15:0] bytes_left_q, bytes_left_n;
	logic        in_payload_q, in_payload_n;
	logic        skipping_q, skipping_n;
	logic        frame_open_q, frame_open_n;
	logic        trunc;
	logic        last_byte;

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_count_q <= '0;
			chunk_type_q   <= '0;
			chunk_length_q <= '0;
			end_mark_q     <= 1'b0;
			chunk_stamp_q  <= '0;
			held_stamp_q   <= '0;
			bytes_left_q   <= '0;
			in_payload_q   <= 1'b0;
			skipping_q     <= 1'b0;
			frame_open_q   <= 1'b0;
		end else if (take) begin
			header_count_q <= header_count_n;
			chunk_type_q   <= chunk_type_n;
			chunk_length_q <= chunk_length_n;
			end_mark_q     <= end_mark_n;
			chunk_stamp_q  <= chunk_stamp_n;
			held_stamp_q   <= held_stamp_n;
			bytes_left_q   <= bytes_left_n;
			in_payload_q   <= in_payload_n;
			skipping_q     <= skipping_n;
			frame_open_q   <= frame_open_n;
		end
	end

	// Classify the byte: header field, kept payload, skipped payload or end of stream
	always_comb begin
		header_count_n = header_count_q;
		chunk_type_n   = chunk_type_q;
		chunk_length_n = chunk_length_q;
		end_mark_n     = end_mark_q;
		chunk_stamp_n  = chunk_stamp_q;
		held_stamp_n   = held_stamp_q;
		bytes_left_n   = bytes_left_q;
		in_payload_n   = in_payload_q;
		skipping_n     = skipping_q;
		frame_open_n   = frame_open_q;
		res            = '0;
		res_valid      = 1'b0;
		trunc          = frame_open_q || (in_payload_q && !skipping_q);
		last_byte      = (bytes_left_q == 16'd1);

		if (stream_end) begin
			// end of stream: everything back to reset, report a cut frame if a kept chunk or frame was open
			header_count_n = '0;
			chunk_type_n   = '0;
			chunk_length_n = '0;
			end_mark_n     = 1'b0;
			chunk_stamp_n  = '0;
			held_stamp_n   = '0;
			bytes_left_n   = '0;
			in_payload_n   = 1'b0;
			skipping_n     = 1'b0;
			frame_open_n   = 1'b0;
			res_valid      = trunc;
			res.stamp      = held_stamp_q;
			res.last       = 1'b1;
			res.status     = vcd_pkg::ST_TRUNC;
		end else if (!in_payload_q) begin
			// header collection, big-endian fields
			case (header_count_q)
				4'd0:    chunk_type_n   = {in_byte, 8'h00};
				4'd1:    chunk_type_n   = {chunk_type_q[15:8], in_byte};
				4'd2:    chunk_length_n = {in_byte, 8'h00};
				4'd3:    chunk_length_n = {chunk_length_q[15:8], in_byte};
				4'd5:    end_mark_n     = in_byte[vcd_pkg::END_FLAG_BIT];
				4'd8:    chunk_stamp_n  = {in_byte, 24'h000000};
				4'd9:    chunk_stamp_n  = {chunk_stamp_q[31:24], in_byte, 16'h0000};
				4'd10:   chunk_stamp_n  = {chunk_stamp_q[31:16], in_byte, 8'h00};
				4'd11:   chunk_stamp_n  = {chunk_stamp_q[31:8], in_byte};
				default: ;
			endcase
			if (header_count_q != 4'(vcd_pkg::HDR_LAST)) begin
				header_count_n = header_count_q + 4'd1;
			end else begin
				header_count_n = '0;
				if (chunk_length_q < vcd_pkg::MIN_LENGTH) begin
					// bad length: drop any open frame, resync on next byte
					frame_open_n = 1'b0;
					res_valid    = 1'b1;
					res.stamp    = frame_open_q ? held_stamp_q : 32'd0;
					res.last     = 1'b1;
					res.status   = vcd_pkg::ST_BAD_LEN;
				end else begin
					bytes_left_n = chunk_length_q - vcd_pkg::HEADER_EXTRA;
					in_payload_n = 1'b1;
					skipping_n   = (chunk_type_q == vcd_pkg::SKIP_TYPE);
					if (chunk_type_q != vcd_pkg::SKIP_TYPE && !frame_open_q) begin
						held_stamp_n = chunk_stamp_q;
					end
				end
			end
		end else begin
			// payload byte
			bytes_left_n = bytes_left_q - 16'd1;
			if (last_byte) begin
				in_payload_n = 1'b0;
			end
			if (skipping_q) begin
				if (last_byte) begin
					skipping_n = 1'b0;
				end
			end else begin
				res_valid    = 1'b1;
				res.data     = in_byte;
				res.stamp    = held_stamp_q;
				res.first    = !frame_open_q;
				res.last     = last_byte && end_mark_q;
				res.status   = vcd_pkg::ST_DATA;
				frame_open_n = !(last_byte && end_mark_q);
			end
		end

		if (!take) begin
			res_valid = 1'b0;
		end
	end

endmodule

`default_nettype wire

### rtl/vcd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vcd_queue #(
	parameter int unsigned DEPTH = vcd_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire vcd_pkg::result_t  wr_data,
	input  wire logic              rd_en,
	output vcd_pkg::result_t       rd_data,
	output logic                   full,
	output logic                   empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	vcd_pkg::result_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count did not grow on write");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

### rtl/video_chunk_deframer_unit.sv
// A result enters the queue as its byte is taken; the queue head drives the result ports.
// Throughput: one byte per cycle, sustained while results are drained as fast.
// Parser takes one byte per cycle unless full; the QUEUE_DEPTH-entry queue absorbs stalls.
// full follows the queue: a byte is refused while the queue holds QUEUE_DEPTH results.
// Reset (arst_n low, asynchronous) empties the queue and clears all parser state.
`timescale 1ns / 1ps
`default_nettype none

module video_chunk_deframer_unit #(
	parameter int unsigned QUEUE_DEPTH = vcd_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        stream_end,
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       out_byte,
	output logic [31:0]      frame_stamp_out,
	output logic             frame_first,
	output logic             frame_last,
	output logic [1:0]       status
);

	vcd_pkg::result_t front_res;
	vcd_pkg::result_t head_res;
	logic             front_valid;
	logic             take;

	assign take = push && !full;

	// Front: header parsing and byte classification
	vcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.res        (front_res),
		.res_valid  (front_valid)
	);

	// Back: result queue toward the consumer
	vcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_res),
		.rd_en   (pop),
		.rd_data (head_res),
		.full    (full),
		.empty   (empty)
	);

	assign out_byte        = head_res.data;
	assign frame_stamp_out = head_res.stamp;
	assign frame_first     = head_res.first;
	assign frame_last      = head_res.last;
	assign status          = head_res.status;

`ifndef SYNTHESIS
	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != vcd_pkg::ST_DATA) |-> (frame_last && !frame_first))
		else $error("status result without frame end");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != vcd_pkg::ST_DATA) |-> (out_byte == 8'd0))
		else $error("status result carries data");
	a_no_lost: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid |-> take)
		else $error("result raised without an accepted byte");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && empty) |=> !empty)
		else $error("result did not reach the output");
`endif

endmodule

`default_nettype wire

### verif/video_chunk_deframer_checker.sv
`timescale 1ns / 1ps

// Watches both request channels of the deframer, predicts its results and
// compares every popped result with the oldest prediction.
module video_chunk_deframer_checker
	import vcd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [7:0]  in_byte,
	input  wire logic        stream_end,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [7:0]  out_byte,
	input  wire logic [31:0] frame_stamp_out,
	input  wire logic        frame_first,
	input  wire logic        frame_last,
	input  wire logic [1:0]  status,
	output int unsigned      mismatches,
	output int unsigned      pending,
	output int unsigned      n_payload,
	output int unsigned      n_bad_len,
	output int unsigned      n_trunc
);

	// Parser state of the prediction
	logic [3:0]  hdr_count;
	logic [15:0] chunk_type;
	logic [15:0] chunk_len;
	logic        end_mark;
	logic [31:0] chunk_stamp;
	logic [31:0] frame_stamp;
	logic [15:0] payload_left;
	logic        in_payload;
	logic        skipping;
	logic        frame_open;

	// Results predicted but not yet popped, oldest first
	result_t due_results[$];

	initial begin
		mismatches = 0;
		pending    = 0;
		n_payload  = 0;
		n_bad_len  = 0;
		n_trunc    = 0;
	end

	task automatic clear_parser();
		hdr_count    = '0;
		chunk_type   = '0;
		chunk_len    = '0;
		end_mark     = 1'b0;
		chunk_stamp  = '0;
		frame_stamp  = '0;
		payload_left = '0;
		in_payload   = 1'b0;
		skipping     = 1'b0;
		frame_open   = 1'b0;
	endtask

	// Advance the parser by one accepted byte; queue any result it causes
	task automatic deframe_byte(input logic [7:0] b, input logic eos);
		result_t r;
		logic    trunc;
		r = '0;
		if (eos) begin
			// end of stream: report a cut frame if a kept chunk or frame was open, then start over
			trunc    = frame_open || (in_payload && !skipping);
			r.stamp  = frame_stamp;
			r.last   = 1'b1;
			r.status = ST_TRUNC;
			clear_parser();
			if (trunc) begin
				due_results.push_back(r);
				n_trunc++;
			end
		end else if (!in_payload) begin
			// header bytes, big-endian
			case (hdr_count)
				4'd0:    chunk_type[15:8]   = b;
				4'd1:    chunk_type[7:0]    = b;
				4'd2:    chunk_len[15:8]    = b;
				4'd3:    chunk_len[7:0]     = b;
				4'd5:    end_mark           = b[END_FLAG_BIT];
				4'd8:    chunk_stamp[31:24] = b;
				4'd9:    chunk_stamp[23:16] = b;
				4'd10:   chunk_stamp[15:8]  = b;
				4'd11:   chunk_stamp[7:0]   = b;
				default: ;
			endcase
			if (hdr_count != 4'(HDR_LAST)) begin
				hdr_count++;
			end else begin
				hdr_count = '0;
				if (chunk_len < MIN_LENGTH) begin
					// bad length: drop any open frame and resync on next byte
					r.stamp    = frame_open ? frame_stamp : 32'd0;
					r.last     = 1'b1;
					r.status   = ST_BAD_LEN;
					frame_open = 1'b0;
					due_results.push_back(r);
					n_bad_len++;
				end else begin
					payload_left = chunk_len - HEADER_EXTRA;
					in_payload   = 1'b1;
					skipping     = (chunk_type == SKIP_TYPE);
					if (!skipping && !frame_open)
						frame_stamp = chunk_stamp;
				end
			end
		end else begin
			// payload byte
			payload_left--;
			if (payload_left == 16'd0)
				in_payload = 1'b0;
			if (skipping) begin
				if (!in_payload)
					skipping = 1'b0;
			end else begin
				r.data     = b;
				r.stamp    = frame_stamp;
				r.first    = !frame_open;
				r.last     = !in_payload && end_mark;
				r.status   = ST_DATA;
				frame_open = !r.last;
				due_results.push_back(r);
				n_payload++;
			end
		end
	endtask

	// Compare the popped result with the oldest prediction
	task automatic check_result();
		result_t exp_r;
		if (due_results.size() == 0) begin
			$error("result popped with none predicted: byte %0h status %0d",
				out_byte, status);
			mismatches++;
		end else begin
			exp_r = due_results.pop_front();
			if (out_byte !== exp_r.data) begin
				$error("out_byte: expected %0h, got %0h", exp_r.data, out_byte);
				mismatches++;
			end
			if (frame_stamp_out !== exp_r.stamp) begin
				$error("frame_stamp_out: expected %0h, got %0h", exp_r.stamp,
					frame_stamp_out);
				mismatches++;
			end
			if (frame_first !== exp_r.first) begin
				$error("frame_first: expected %0b, got %0b", exp_r.first, frame_first);
				mismatches++;
			end
			if (frame_last !== exp_r.last) begin
				$error("frame_last: expected %0b, got %0b", exp_r.last, frame_last);
				mismatches++;
			end
			if (status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, status);
				mismatches++;
			end
		end
	endtask

	// Results are checked before the same edge's byte is predicted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			due_results.delete();
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				deframe_byte(in_byte, stream_end);
		end
		pending = due_results.size();
	end

endmodule

### verif/video_chunk_deframer_unit_tb.sv
`timescale 1ns / 1ps

module video_chunk_deframer_unit_tb;
	import vcd_pkg::*;

	localparam int unsigned ITEM_TARGET = 1050;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned LONG_HOLD   = 300;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic [7:0]  in_byte    = 8'd0;
	logic        stream_end = 1'b0;
	logic        pop        = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic [31:0] frame_stamp_out;
	logic        frame_first;
	logic        frame_last;
	logic [1:0]  status;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned n_payload;
	int unsigned n_bad_len;
	int unsigned n_trunc;

	int unsigned bytes_sent = 0;
	int unsigned send_idle  = 0;
	int unsigned recv_idle  = 0;
	int unsigned idle_run   = 0;
	int unsigned hold_left  = 0;
	bit          hold_req   = 1'b0;

	video_chunk_deframer_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.in_byte         (in_byte),
		.stream_end      (stream_end),
		.empty           (empty),
		.pop             (pop),
		.out_byte        (out_byte),
		.frame_stamp_out (frame_stamp_out),
		.frame_first     (frame_first),
		.frame_last      (frame_last),
		.status          (status)
	);

	video_chunk_deframer_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.in_byte         (in_byte),
		.stream_end      (stream_end),
		.empty           (empty),
		.pop             (pop),
		.out_byte        (out_byte),
		.frame_stamp_out (frame_stamp_out),
		.frame_first     (frame_first),
		.frame_last      (frame_last),
		.status          (status),
		.mismatches      (mismatches),
		.pending         (pending),
		.n_payload       (n_payload),
		.n_bad_len       (n_bad_len),
		.n_trunc         (n_trunc)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Result side: random pops, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
				pop <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog: too many cycles without any accepted request
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// One input request, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push       <= 1'b1;
		in_byte    <= b;
		stream_end <= eos;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic send_end();
		send_byte(8'($urandom), 1'b1);
	endtask

	task automatic send_header(input logic [15:0] ctype, input logic [15:0] len,
		input logic [15:0] flags, input logic [31:0] stamp);
		send_byte(ctype[15:8], 1'b0);
		send_byte(ctype[7:0], 1'b0);
		send_byte(len[15:8], 1'b0);
		send_byte(len[7:0], 1'b0);
		send_byte(flags[15:8], 1'b0);
		send_byte(flags[7:0], 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b0);
		send_byte(stamp[31:24], 1'b0);
		send_byte(stamp[23:16], 1'b0);
		send_byte(stamp[15:8], 1'b0);
		send_byte(stamp[7:0], 1'b0);
		repeat (4) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_noise(input int unsigned n);
		repeat (n) send_byte(8'($urandom), 1'b0);
	endtask

	// Whole chunk: header, then its payload when the length is legal
	task automatic send_chunk(input logic [15:0] ctype, input logic [15:0] len,
		input logic end_bit, input logic [31:0] stamp);
		logic [15:0] flags;
		flags    = 16'($urandom);
		flags[7] = end_bit;
		send_header(ctype, len, flags, stamp);
		if (len >= MIN_LENGTH)
			send_noise(len - HEADER_EXTRA);
	endtask

	function automatic logic [31:0] pick_stamp();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_kept_type();
		logic [15:0] t;
		t = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
		if (t == SKIP_TYPE)
			t = t + 16'd1;
		return t;
	endfunction

	// One random stream fragment; mostly well-formed frames
	task automatic random_fragment();
		logic [15:0] len;
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 55) begin
			len = MIN_LENGTH + 16'($urandom_range(($urandom_range(9) == 0) ? 40 : 6));
			send_chunk(pick_kept_type(), len, $urandom_range(99) < 40, pick_stamp());
		end else if (sel < 67) begin
			len = MIN_LENGTH + 16'($urandom_range(6));
			send_chunk(SKIP_TYPE, len, 1'($urandom), pick_stamp());
		end else if (sel < 75) begin
			send_chunk(16'($urandom), 16'($urandom_range(12)), 1'($urandom), pick_stamp());
		end else if (sel < 83) begin
			// long chunk cut off by end of stream
			len = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(100, 65535));
			send_header(pick_kept_type(), len, 16'($urandom), pick_stamp());
			send_noise($urandom_range(6));
			send_end();
		end else if (sel < 90) begin
			send_end();
		end else if (sel < 95) begin
			// header cut short
			send_noise($urandom_range(1, 15));
			send_end();
		end else begin
			send_noise($urandom_range(1, 20));
			send_end();
		end
	endtask

	// Stimulus and verdict
	initial begin
		send_idle = 18;
		recv_idle = 80;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: end of stream while idle, bad length with extreme bytes,
		// minimal closed frame, skipped chunk inside an open frame, cut frame
		send_end();
		send_header(16'hFFFF, 16'd12, 16'hFFFF, 32'hFFFF_FFFF);
		send_header(16'h0000, 16'd0, 16'h0000, 32'h0000_0000);
		send_chunk(16'h0000, MIN_LENGTH, 1'b1, 32'h0000_0000);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_end();
		send_chunk(16'h1234, MIN_LENGTH + 16'd1, 1'b0, 32'hA5A5_5A5A);
		send_chunk(SKIP_TYPE, MIN_LENGTH + 16'd1, 1'b1, 32'h1111_2222);
		send_chunk(16'h4321, MIN_LENGTH, 1'b1, 32'h3333_4444);
		send_chunk(16'h0001, MIN_LENGTH + 16'd2, 1'b0, 32'hFFFF_FFFF);
		send_end();

		// Random: three idle profiles
		while (bytes_sent < 400)
			random_fragment();
		send_idle = 80;
		recv_idle = 18;
		while (bytes_sent < 730)
			random_fragment();
		send_idle = 0;
		recv_idle = 0;
		hold_req  = 1'b1;
		while (bytes_sent < ITEM_TARGET)
			random_fragment();
		send_end();
		push <= 1'b0;

		// Drain, then allow for any late extra result
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d stream bytes under three idle profiles and a long output stall.",
			bytes_sent);
		$display("Checked %0d payload bytes, %0d bad-length and %0d truncation results.",
			n_payload, n_bad_len, n_trunc);
		if (mismatches == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

### video_chunk_deframer_unit.f
rtl/vcd_pkg.sv
rtl/vcd_front.sv
rtl/vcd_queue.sv
rtl/video_chunk_deframer_unit.sv
verif/video_chunk_deframer_checker.sv
verif/video_chunk_deframer_unit_tb.sv
